[hdl/cle_pkg.sv]
// Shared types, codes and constants of the console line editor.
package cle_pkg;

   localparam int OP_W       = 2;
   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 2;
   localparam int STAT_W     = 2;
   localparam int LEN_W      = 5;
   localparam int TICK_W     = 20;
   localparam int SIZE_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam int SEQ_W      = 5;
   localparam int MSG_LEN    = 19;
   localparam int ERASE_LEN  = 3;

   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_SUBMIT  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_CANCEL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_TIMEOUT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_BUF_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ECHO     = 2'd2;

   localparam logic [SIZE_W-1:0] BUF_SIZE_RESET = 6'd32;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET  = 20'd30000;
   localparam logic              ECHO_RESET     = 1'b1;
   localparam logic [TICK_W-1:0] TICK_MAX       = '1;

   localparam logic [BYTE_W-1:0] CH_BELL  = 8'd7;
   localparam logic [BYTE_W-1:0] CH_BS    = 8'd8;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
   localparam logic [BYTE_W-1:0] CH_ESC   = 8'd27;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
   localparam logic [BYTE_W-1:0] CH_TILDE = 8'd126;
   localparam logic [BYTE_W-1:0] CH_DEL   = 8'd127;

   typedef enum logic [2:0] {
      CLS_START,
      CLS_IGNORE,
      CLS_TICK,
      CLS_ENTER,
      CLS_ERASE,
      CLS_CANCEL,
      CLS_PRINT
   } cls_type;

   typedef enum logic [2:0] {
      SEL_RX,
      SEL_BELL,
      SEL_NL,
      SEL_BS,
      SEL_SPACE,
      SEL_CANCEL,
      SEL_LINE,
      SEL_END
   } sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_NL,
      ST_STREAM,
      ST_END,
      ST_BS,
      ST_MSG,
      ST_CHAR,
      ST_BELL
   } state_type;

   typedef struct packed {
      logic              load;
      logic              start;
      logic              tick;
      logic              erase;
      logic              store;
      logic              emit;
      sel_type           sel;
      logic [SEQ_W-1:0]  seq;
      logic [STAT_W-1:0] stat;
      logic              last;
      logic              idx_inc;
      logic              close;
   } cmd_type;

   typedef struct packed {
      cls_type cls;
      logic    has_room;
      logic    fill_zero;
      logic    echo_en;
      logic    timeout_hit;
      logic    stream_last;
      logic    out_free;
   } stat_type;

   function automatic logic [BYTE_W-1:0] cancel_char(input logic [SEQ_W-1:0] pos);
      logic [BYTE_W-1:0] ch;
      unique case (pos)
         5'd0:    ch = CH_LF;
         5'd1:    ch = 8'h5B;
         5'd2:    ch = 8'h49;
         5'd3:    ch = 8'h6E;
         5'd4:    ch = 8'h70;
         5'd5:    ch = 8'h75;
         5'd6:    ch = 8'h74;
         5'd7:    ch = CH_SPACE;
         5'd8:    ch = 8'h63;
         5'd9:    ch = 8'h61;
         5'd10:   ch = 8'h6E;
         5'd11:   ch = 8'h63;
         5'd12:   ch = 8'h65;
         5'd13:   ch = 8'h6C;
         5'd14:   ch = 8'h6C;
         5'd15:   ch = 8'h65;
         5'd16:   ch = 8'h64;
         5'd17:   ch = 8'h5D;
         5'd18:   ch = CH_LF;
         default: ch = '0;
      endcase
      return ch;
   endfunction

endpackage

[hdl/cle_if.sv]
// Channel interfaces of the console line editor: request, response and register write.
interface cle_req_if;
   logic                          valid;
   logic                          ready;
   logic [cle_pkg::OP_W-1:0]      opcode;
   logic [cle_pkg::BYTE_W-1:0]    rx_byte;
   modport source (output valid, opcode, rx_byte, input ready);
   modport sink   (input valid, opcode, rx_byte, output ready);
endinterface

interface cle_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cle_pkg::KIND_W-1:0]    out_kind;
   logic [cle_pkg::BYTE_W-1:0]    out_byte;
   logic [cle_pkg::STAT_W-1:0]    end_status;
   logic [cle_pkg::LEN_W-1:0]     line_length;
   logic                          last;
   modport source (output valid, out_kind, out_byte, end_status, line_length, last,
                   input ready);
   modport sink   (input valid, out_kind, out_byte, end_status, line_length, last,
                   output ready);
endinterface

interface cle_csr_if;
   logic                            valid;
   logic                            ready;
   logic [cle_pkg::CSR_IDX_W-1:0]   reg_index;
   logic [cle_pkg::CSR_DATA_W-1:0]  wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[hdl/cle_datapath.sv]
// Datapath of the console line editor: registers, session state, line store and output register.
module cle_datapath #(
   parameter int LINE_BYTES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cle_pkg::cmd_type                  cmd,
   output cle_pkg::stat_type                 stat,
   input  logic [cle_pkg::OP_W-1:0]          req_opcode,
   input  logic [cle_pkg::BYTE_W-1:0]        req_rx_byte,
   input  logic                              csr_valid,
   input  logic [cle_pkg::CSR_IDX_W-1:0]     csr_reg_index,
   input  logic [cle_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cle_pkg::KIND_W-1:0]        rsp_out_kind,
   output logic [cle_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic [cle_pkg::STAT_W-1:0]        rsp_end_status,
   output logic [cle_pkg::LEN_W-1:0]         rsp_line_length,
   output logic                              rsp_last
);

   localparam int FILL_W = $clog2(LINE_BYTES);
   localparam logic [cle_pkg::SIZE_W-1:0] SIZE_MAX = cle_pkg::SIZE_W'(LINE_BYTES);

   logic [cle_pkg::SIZE_W-1:0]   buf_size_ff, buf_size_in;
   logic [cle_pkg::TICK_W-1:0]   timeout_ff, timeout_in;
   logic                         echo_en_ff, echo_en_in;
   logic                         in_session_ff, in_session_in;
   logic [FILL_W-1:0]            fill_ff, fill_in;
   logic [cle_pkg::TICK_W-1:0]   elapsed_ff, elapsed_in;
   logic [FILL_W-1:0]            idx_ff, idx_in;
   logic [cle_pkg::OP_W-1:0]     op_ff, op_in;
   logic [cle_pkg::BYTE_W-1:0]   byte_ff, byte_in;
   logic [cle_pkg::BYTE_W-1:0]   rd_data_ff;
   logic [cle_pkg::BYTE_W-1:0]   line_mem [LINE_BYTES];

   logic                         valid_ff, valid_in;
   logic [cle_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [cle_pkg::BYTE_W-1:0]   obyte_ff, obyte_in;
   logic [cle_pkg::STAT_W-1:0]   ostat_ff, ostat_in;
   logic [cle_pkg::LEN_W-1:0]    olen_ff, olen_in;
   logic                         olast_ff, olast_in;

   logic [cle_pkg::SIZE_W-1:0]   size_eff;
   logic [cle_pkg::TICK_W-1:0]   ticks_next;
   cle_pkg::cls_type             cls;

   always_comb begin
      priority if (op_ff == cle_pkg::OP_START) begin
         cls = cle_pkg::CLS_START;
      end else if (!in_session_ff || op_ff == cle_pkg::OP_NONE) begin
         cls = cle_pkg::CLS_IGNORE;
      end else if (op_ff == cle_pkg::OP_TICK) begin
         cls = cle_pkg::CLS_TICK;
      end else if (byte_ff == cle_pkg::CH_CR || byte_ff == cle_pkg::CH_LF) begin
         cls = cle_pkg::CLS_ENTER;
      end else if (byte_ff == cle_pkg::CH_BS || byte_ff == cle_pkg::CH_DEL) begin
         cls = cle_pkg::CLS_ERASE;
      end else if (byte_ff == cle_pkg::CH_ESC) begin
         cls = cle_pkg::CLS_CANCEL;
      end else if (byte_ff >= cle_pkg::CH_SPACE && byte_ff <= cle_pkg::CH_TILDE) begin
         cls = cle_pkg::CLS_PRINT;
      end else begin
         cls = cle_pkg::CLS_IGNORE;
      end
   end

   assign size_eff   = (buf_size_ff > SIZE_MAX) ? SIZE_MAX : buf_size_ff;
   assign ticks_next = (elapsed_ff == cle_pkg::TICK_MAX) ? elapsed_ff
                                                         : elapsed_ff + 1'b1;

   always_comb begin
      stat.cls         = cls;
      stat.has_room    = (7'(fill_ff) + 7'd1) < 7'(size_eff);
      stat.fill_zero   = (fill_ff == '0);
      stat.echo_en     = echo_en_ff;
      stat.timeout_hit = (timeout_ff != '0) && (ticks_next >= timeout_ff);
      stat.stream_last = (({1'b0, idx_ff} + 1'b1) == {1'b0, fill_ff});
      stat.out_free    = !valid_ff || rsp_ready;
   end

   always_comb begin
      buf_size_in = buf_size_ff;
      timeout_in  = timeout_ff;
      echo_en_in  = echo_en_ff;
      if (csr_valid) begin
         unique case (csr_reg_index)
            cle_pkg::REG_BUF_SIZE: buf_size_in = cle_pkg::SIZE_W'(csr_wdata);
            cle_pkg::REG_TIMEOUT:  timeout_in  = cle_pkg::TICK_W'(csr_wdata);
            cle_pkg::REG_ECHO:     echo_en_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_session_in = in_session_ff;
      fill_in       = fill_ff;
      elapsed_in    = elapsed_ff;
      idx_in        = idx_ff;
      op_in         = op_ff;
      byte_in       = byte_ff;
      if (cmd.load) begin
         op_in   = req_opcode;
         byte_in = req_rx_byte;
         idx_in  = '0;
      end
      if (cmd.start) begin
         in_session_in = 1'b1;
         fill_in       = '0;
         elapsed_in    = '0;
      end
      if (cmd.tick) begin
         elapsed_in = ticks_next;
      end
      if (cmd.erase) begin
         fill_in = fill_ff - 1'b1;
      end
      if (cmd.store) begin
         fill_in = fill_ff + 1'b1;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.close) begin
         in_session_in = 1'b0;
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      kind_in  = kind_ff;
      obyte_in = obyte_ff;
      ostat_in = ostat_ff;
      olen_in  = olen_ff;
      olast_in = olast_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         kind_in  = cle_pkg::KIND_ECHO;
         obyte_in = '0;
         ostat_in = cle_pkg::STAT_SUBMIT;
         olen_in  = '0;
         olast_in = cmd.last;
         unique case (cmd.sel)
            cle_pkg::SEL_RX:     obyte_in = byte_ff;
            cle_pkg::SEL_BELL:   obyte_in = cle_pkg::CH_BELL;
            cle_pkg::SEL_NL:     obyte_in = cle_pkg::CH_LF;
            cle_pkg::SEL_BS:     obyte_in = cle_pkg::CH_BS;
            cle_pkg::SEL_SPACE:  obyte_in = cle_pkg::CH_SPACE;
            cle_pkg::SEL_CANCEL: obyte_in = cle_pkg::cancel_char(cmd.seq);
            cle_pkg::SEL_LINE: begin
               kind_in  = cle_pkg::KIND_LINE;
               obyte_in = rd_data_ff;
            end
            cle_pkg::SEL_END: begin
               kind_in  = cle_pkg::KIND_END;
               ostat_in = cmd.stat;
               olen_in  = (cmd.stat == cle_pkg::STAT_CANCEL) ? '0
                                                             : cle_pkg::LEN_W'(fill_ff);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_size_ff   <= cle_pkg::BUF_SIZE_RESET;
         timeout_ff    <= cle_pkg::TIMEOUT_RESET;
         echo_en_ff    <= cle_pkg::ECHO_RESET;
         in_session_ff <= 1'b0;
         fill_ff       <= '0;
         elapsed_ff    <= '0;
         idx_ff        <= '0;
         valid_ff      <= 1'b0;
      end else begin
         buf_size_ff   <= buf_size_in;
         timeout_ff    <= timeout_in;
         echo_en_ff    <= echo_en_in;
         in_session_ff <= in_session_in;
         fill_ff       <= fill_in;
         elapsed_ff    <= elapsed_in;
         idx_ff        <= idx_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      byte_ff  <= byte_in;
      kind_ff  <= kind_in;
      obyte_ff <= obyte_in;
      ostat_ff <= ostat_in;
      olen_ff  <= olen_in;
      olast_ff <= olast_in;
   end

   // The read address follows the next index, so the read data always matches idx_ff.
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         line_mem[fill_ff] <= byte_ff;
      end
      rd_data_ff <= line_mem[idx_in];
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_kind    = kind_ff;
   assign rsp_out_byte    = obyte_ff;
   assign rsp_end_status  = ostat_ff;
   assign rsp_line_length = olen_ff;
   assign rsp_last        = olast_ff;

endmodule

[hdl/cle_controller.sv]
// Controller of the console line editor: sequences decoding, echo, line streaming and end records.
module cle_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  cle_pkg::stat_type  stat,
   output cle_pkg::cmd_type   cmd
);

   cle_pkg::state_type                state_ff, state_in;
   logic [cle_pkg::SEQ_W-1:0]         seq_ff, seq_in;
   logic [cle_pkg::STAT_W-1:0]        end_stat_ff, end_stat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= cle_pkg::ST_IDLE;
         seq_ff      <= '0;
         end_stat_ff <= cle_pkg::STAT_SUBMIT;
      end else begin
         state_ff    <= state_in;
         seq_ff      <= seq_in;
         end_stat_ff <= end_stat_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      seq_in      = seq_ff;
      end_stat_in = end_stat_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.sel     = cle_pkg::SEL_END;
      cmd.seq     = seq_ff;
      cmd.stat    = end_stat_ff;
      unique case (state_ff)
         cle_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = cle_pkg::ST_DECODE;
            end
         end
         cle_pkg::ST_DECODE: begin
            seq_in = '0;
            unique case (stat.cls)
               cle_pkg::CLS_START: begin
                  cmd.start = 1'b1;
                  state_in  = cle_pkg::ST_IDLE;
               end
               cle_pkg::CLS_IGNORE: begin
                  state_in = cle_pkg::ST_IDLE;
               end
               cle_pkg::CLS_TICK: begin
                  cmd.tick    = 1'b1;
                  end_stat_in = cle_pkg::STAT_TIMEOUT;
                  state_in    = stat.timeout_hit ? cle_pkg::ST_END : cle_pkg::ST_IDLE;
               end
               cle_pkg::CLS_ENTER: begin
                  end_stat_in = cle_pkg::STAT_SUBMIT;
                  if (stat.echo_en) begin
                     state_in = cle_pkg::ST_NL;
                  end else begin
                     state_in = stat.fill_zero ? cle_pkg::ST_END : cle_pkg::ST_STREAM;
                  end
               end
               cle_pkg::CLS_ERASE: begin
                  if (stat.fill_zero) begin
                     state_in = cle_pkg::ST_IDLE;
                  end else begin
                     cmd.erase = 1'b1;
                     state_in  = stat.echo_en ? cle_pkg::ST_BS : cle_pkg::ST_IDLE;
                  end
               end
               cle_pkg::CLS_CANCEL: begin
                  end_stat_in = cle_pkg::STAT_CANCEL;
                  state_in    = stat.echo_en ? cle_pkg::ST_MSG : cle_pkg::ST_END;
               end
               cle_pkg::CLS_PRINT: begin
                  if (stat.has_room) begin
                     cmd.store = 1'b1;
                     state_in  = stat.echo_en ? cle_pkg::ST_CHAR : cle_pkg::ST_IDLE;
                  end else begin
                     state_in  = stat.echo_en ? cle_pkg::ST_BELL : cle_pkg::ST_IDLE;
                  end
               end
               default: begin
                  state_in = cle_pkg::ST_IDLE;
               end
            endcase
         end
         cle_pkg::ST_NL: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = cle_pkg::SEL_NL;
               state_in = stat.fill_zero ? cle_pkg::ST_END : cle_pkg::ST_STREAM;
            end
         end
         cle_pkg::ST_STREAM: begin
            if (stat.out_free) begin
               cmd.emit    = 1'b1;
               cmd.sel     = cle_pkg::SEL_LINE;
               cmd.idx_inc = 1'b1;
               if (stat.stream_last) begin
                  state_in = cle_pkg::ST_END;
               end
            end
         end
         cle_pkg::ST_END: begin
            if (stat.out_free) begin
               cmd.emit  = 1'b1;
               cmd.sel   = cle_pkg::SEL_END;
               cmd.last  = 1'b1;
               cmd.close = 1'b1;
               state_in  = cle_pkg::ST_IDLE;
            end
         end
         cle_pkg::ST_BS: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = (seq_ff == 5'd1) ? cle_pkg::SEL_SPACE : cle_pkg::SEL_BS;
               cmd.last = (seq_ff == cle_pkg::SEQ_W'(cle_pkg::ERASE_LEN - 1));
               seq_in   = seq_ff + 1'b1;
               if (cmd.last) begin
                  state_in = cle_pkg::ST_IDLE;
               end
            end
         end
         cle_pkg::ST_MSG: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = cle_pkg::SEL_CANCEL;
               seq_in   = seq_ff + 1'b1;
               if (seq_ff == cle_pkg::SEQ_W'(cle_pkg::MSG_LEN - 1)) begin
                  state_in = cle_pkg::ST_END;
               end
            end
         end
         cle_pkg::ST_CHAR: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = cle_pkg::SEL_RX;
               cmd.last = 1'b1;
               state_in = cle_pkg::ST_IDLE;
            end
         end
         cle_pkg::ST_BELL: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = cle_pkg::SEL_BELL;
               cmd.last = 1'b1;
               state_in = cle_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cle_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[hdl/console_line_editor_unit.sv]
// Top level of the console line editor: controller, datapath and channel ports.
// The unit takes one request at a time: a request is transferred while idle and
// decoded in the next state, so a start, a tick without timeout or an ignored byte
// ends there. Each result is then emitted from its own state while the response
// side keeps up: the single output register holds one result, and the line store
// is read one character a cycle unless the response side stalls. With echo on, a
// printable byte gives one result, an erase three, an enter with n characters n + 2,
// a cancel 20. Results are held until they are transferred; the next request is
// taken while the prior final result waits. Register writes are taken in any cycle.
module console_line_editor_unit #(
   parameter int LINE_BYTES = 32
) (
   input  logic          clock,
   input  logic          reset,
   cle_req_if.sink       req_chan,
   cle_rsp_if.source     rsp_chan,
   cle_csr_if.sink       csr_chan
);

   cle_pkg::cmd_type  cmd;
   cle_pkg::stat_type stat;

   assign csr_chan.ready = 1'b1;

   cle_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cle_datapath #(
      .LINE_BYTES (LINE_BYTES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_chan.opcode),
      .req_rx_byte     (req_chan.rx_byte),
      .csr_valid       (csr_chan.valid),
      .csr_reg_index   (csr_chan.reg_index),
      .csr_wdata       (csr_chan.wdata),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_out_kind    (rsp_chan.out_kind),
      .rsp_out_byte    (rsp_chan.out_byte),
      .rsp_end_status  (rsp_chan.end_status),
      .rsp_line_length (rsp_chan.line_length),
      .rsp_last        (rsp_chan.last)
   );

endmodule

[hdl/cle_checker.sv]
// Port-level checker of the console line editor and its bind to the top level.
module cle_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [cle_pkg::KIND_W-1:0]      rsp_out_kind,
   input logic [cle_pkg::BYTE_W-1:0]      rsp_out_byte,
   input logic [cle_pkg::STAT_W-1:0]      rsp_end_status,
   input logic [cle_pkg::LEN_W-1:0]       rsp_line_length,
   input logic                            rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_kind) &&
      $stable(rsp_out_byte) && $stable(rsp_end_status) &&
      $stable(rsp_line_length) && $stable(rsp_last))
      else $error("Response changed while a transfer was pending.");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid right after reset.");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == cle_pkg::KIND_END |-> rsp_last && rsp_out_byte == '0)
      else $error("End record is not the final result or carries a byte.");

   a_char_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind != cle_pkg::KIND_END |->
      rsp_end_status == '0 && rsp_line_length == '0)
      else $error("Echo or line character carries end record fields.");

endmodule

bind console_line_editor_unit cle_checker u_cle_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_out_kind    (rsp_chan.out_kind),
   .rsp_out_byte    (rsp_chan.out_byte),
   .rsp_end_status  (rsp_chan.end_status),
   .rsp_line_length (rsp_chan.line_length),
   .rsp_last        (rsp_chan.last)
);

[tb/tb_console_line_editor_unit.sv]
// Testbench of the console line editor: directed and random sessions checked by a scoreboard.
module tb_console_line_editor_unit;
   import cle_pkg::*;

   localparam int LINE_CAP      = 32;
   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 100;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
      logic [STAT_W-1:0] status;
      logic [LEN_W-1:0]  length;
      logic              last;
   } editor_result_type;

   class line_editor_tracker;
      logic [SIZE_W-1:0] cfg_buf_size;
      logic [TICK_W-1:0] cfg_timeout;
      logic              cfg_echo;
      bit                session_open;
      logic [BYTE_W-1:0] line_chars [LINE_CAP];
      logic [SIZE_W-1:0] char_count;
      logic [TICK_W-1:0] tick_count;
      editor_result_type pending_results [$];
      editor_result_type held;
      bit                held_valid;
      int                mismatches;
      string             cancel_text = "\n[Input cancelled]\n";

      function new();
         cfg_buf_size = BUF_SIZE_RESET;
         cfg_timeout  = TIMEOUT_RESET;
         cfg_echo     = ECHO_RESET;
         session_open = 1'b0;
         char_count   = '0;
         tick_count   = '0;
         held_valid   = 1'b0;
         mismatches   = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_BUF_SIZE: cfg_buf_size = data[SIZE_W-1:0];
            REG_TIMEOUT:  cfg_timeout  = data[TICK_W-1:0];
            REG_ECHO:     cfg_echo     = data[0];
            default: ;
         endcase
      endfunction

      function void add(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                        logic [STAT_W-1:0] status, logic [LEN_W-1:0] length);
         if (held_valid) pending_results.push_back(held);
         held = '{kind, data, status, length, 1'b0};
         held_valid = 1'b1;
      endfunction

      function void add_echo(logic [BYTE_W-1:0] data);
         if (cfg_echo) add(KIND_ECHO, data, '0, '0);
      endfunction

      // Returns 1 for a start and for any request other than a no-op code inside a session.
      function bit take_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] ch);
         int size;
         int cap;
         held_valid = 1'b0;
         if (op == OP_START) begin
            session_open = 1'b1;
            char_count   = '0;
            tick_count   = '0;
            return 1'b1;
         end
         if (!session_open || op == OP_NONE) return 1'b0;
         size = (int'(cfg_buf_size) > LINE_CAP) ? LINE_CAP : int'(cfg_buf_size);
         cap  = (size == 0) ? 0 : size - 1;
         if (op == OP_TICK) begin
            if (tick_count != TICK_MAX) tick_count++;
            if (cfg_timeout != '0 && tick_count >= cfg_timeout) begin
               add(KIND_END, '0, STAT_TIMEOUT, char_count[LEN_W-1:0]);
               session_open = 1'b0;
            end
         end else if (ch == CH_CR || ch == CH_LF) begin
            add_echo(CH_LF);
            for (int i = 0; i < int'(char_count) && i < LINE_CAP; i++)
               add(KIND_LINE, line_chars[i], '0, '0);
            add(KIND_END, '0, STAT_SUBMIT, char_count[LEN_W-1:0]);
            session_open = 1'b0;
         end else if (ch == CH_BS || ch == CH_DEL) begin
            if (char_count != '0) begin
               char_count--;
               add_echo(CH_BS);
               add_echo(CH_SPACE);
               add_echo(CH_BS);
            end
         end else if (ch == CH_ESC) begin
            for (int i = 0; i < cancel_text.len(); i++) add_echo(cancel_text[i]);
            add(KIND_END, '0, STAT_CANCEL, '0);
            char_count   = '0;
            session_open = 1'b0;
         end else if (ch >= CH_SPACE && ch <= CH_TILDE) begin
            if (int'(char_count) < cap) begin
               line_chars[char_count] = ch;
               char_count++;
               add_echo(ch);
            end else begin
               add_echo(CH_BELL);
            end
         end
         if (held_valid) begin
            held.last = 1'b1;
            pending_results.push_back(held);
         end
         return 1'b1;
      endfunction

      function void check_response(editor_result_type got);
         editor_result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: kind %0d byte %02h status %0d length %0d last %0d",
                        got.kind, got.data, got.status, got.length, got.last);
            return;
         end
         want = pending_results.pop_front();
         if (got.kind !== want.kind || got.data !== want.data || got.status !== want.status ||
             got.length !== want.length || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("mismatch: expected kind %0d byte %02h status %0d length %0d last %0d, %s",
                        want.kind, want.data, want.status, want.length, want.last,
                        $sformatf("got kind %0d byte %02h status %0d length %0d last %0d",
                                  got.kind, got.data, got.status, got.length, got.last));
         end
      endfunction

      function bit clean();
         if (pending_results.size() != 0)
            $display("%0d expected results never arrived", pending_results.size());
         return mismatches == 0 && pending_results.size() == 0;
      endfunction
   endclass

   logic clock;
   logic reset;

   cle_req_if req_bus ();
   cle_rsp_if rsp_bus ();
   cle_csr_if csr_bus ();

   console_line_editor_unit #(
      .LINE_BYTES(LINE_CAP)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   line_editor_tracker sb = new();
   editor_result_type  seen;
   int                 counted_items;
   int                 phase_items;
   int                 idle_cycles;
   bit                 no_gaps;
   bit                 hold_request;
   int                 hold_left;
   int                 run_left;
   int                 stall_left;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] ch);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.opcode  <= op;
      req_bus.rx_byte <= ch;
      do @(posedge clock); while (!req_bus.ready);
      if (sb.take_request(op, ch)) begin
         counted_items++;
         phase_items++;
      end
   endtask

   task automatic send_printable();
      send_item(OP_BYTE, 8'($urandom_range(32, 126)));
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending_results.size() != 0);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wdata     <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      sb.set_register(idx, data);
   endtask

   task automatic apply_settings(logic [SIZE_W-1:0] size, logic [TICK_W-1:0] limit,
                                 logic echo_on);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(REG_BUF_SIZE, CSR_DATA_W'(size));
      write_register(REG_TIMEOUT, CSR_DATA_W'(limit));
      write_register(REG_ECHO, CSR_DATA_W'(echo_on));
   endtask

   // Mostly well-formed sessions with random content, mixed with noise.
   task automatic random_session();
      int n;
      int r;
      no_gaps = ($urandom_range(0, 3) == 0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 12);
      send_item(OP_START, 8'($urandom));
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 58) send_printable();
         else if (r < 70) send_item(OP_BYTE, $urandom_range(0, 1) ? CH_BS : CH_DEL);
         else if (r < 80) send_item(OP_TICK, 8'($urandom));
         else if (r < 86) send_item(OP_NONE, 8'($urandom));
         else if (r < 90) send_item(2'($urandom), 8'($urandom));
         else send_item(OP_BYTE, 8'($urandom));
      end
      r = $urandom_range(0, 99);
      if (r < 40) send_item(OP_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF);
      else if (r < 60) send_item(OP_BYTE, CH_ESC);
      else if (r < 85 && sb.cfg_timeout != '0 && sb.cfg_timeout <= 48)
         repeat (int'(sb.cfg_timeout)) send_item(OP_TICK, 8'($urandom));
      no_gaps = 1'b0;
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      hold_left     = 0;
      run_left      = 0;
      stall_left    = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (run_left == 0 && stall_left == 0) begin
               if ($urandom_range(0, 9) < 3) begin
                  run_left = $urandom_range(20, 80);
               end else begin
                  run_left   = $urandom_range(1, 6);
                  stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3)
                                                          : $urandom_range(10, 60);
               end
            end
            if (stall_left > 0) begin
               stall_left--;
               rsp_bus.ready <= 1'b0;
            end else begin
               run_left--;
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen = '{rsp_bus.out_kind, rsp_bus.out_byte, rsp_bus.end_status,
                  rsp_bus.line_length, rsp_bus.last};
         sb.check_response(seen);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("console_line_editor_unit test failed");
            $finish;
         end
      end
   end

   initial begin
      logic [SIZE_W-1:0] size;
      logic [TICK_W-1:0] limit;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.opcode    = OP_NONE;
      req_bus.rx_byte   = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.reg_index = REG_BUF_SIZE;
      csr_bus.wdata     = '0;
      hold_request      = 1'b0;
      no_gaps           = 1'b0;
      counted_items     = 0;
      phase_items       = 0;
      idle_cycles       = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: items outside a session, restart, ignored codes, edits, submit, cancel.
      send_item(OP_TICK, 8'h00);
      send_item(OP_BYTE, 8'h41);
      send_item(OP_START, 8'h00);
      send_item(OP_BYTE, 8'h71);
      send_item(OP_START, 8'hFF);
      send_item(OP_NONE, 8'hFF);
      send_item(OP_BYTE, 8'h80);
      send_item(OP_BYTE, 8'h00);
      send_item(OP_BYTE, CH_BS);
      send_item(OP_BYTE, CH_SPACE);
      send_item(OP_BYTE, CH_TILDE);
      send_item(OP_BYTE, CH_DEL);
      send_item(OP_BYTE, 8'h7A);
      send_item(OP_BYTE, CH_CR);
      send_item(OP_START, 8'h00);
      send_item(OP_BYTE, 8'h78);
      send_item(OP_BYTE, CH_ESC);

      // Zero buffer size rings the bell; zero timeout never expires.
      apply_settings(6'd0, 20'd0, 1'b1);
      send_item(OP_START, 8'h00);
      send_item(OP_BYTE, 8'h61);
      send_item(OP_TICK, 8'h00);
      send_item(OP_BYTE, CH_LF);

      // Largest buffer size, echo off, short timeout.
      apply_settings(6'd63, 20'd2, 1'b0);
      send_item(OP_START, 8'h00);
      send_item(OP_BYTE, 8'h61);
      send_item(OP_TICK, 8'h00);
      send_item(OP_TICK, 8'h00);

      // Largest timeout, then the buffer shrinks and the timeout drops below the count.
      apply_settings(6'd32, TICK_MAX, 1'b1);
      send_item(OP_START, 8'h00);
      repeat (3) send_printable();
      send_item(OP_TICK, 8'h00);
      send_item(OP_TICK, 8'h00);
      apply_settings(6'd2, 20'd1, 1'b1);
      send_item(OP_BYTE, 8'h6B);
      send_item(OP_TICK, 8'h00);

      // The response side holds off while a long line is offered without gaps.
      apply_settings(BUF_SIZE_RESET, TIMEOUT_RESET, ECHO_RESET);
      phase_items   = 0;
      hold_request  = 1'b1;
      no_gaps       = 1'b1;
      send_item(OP_START, 8'h00);
      repeat (24) send_printable();
      send_item(OP_BYTE, CH_CR);
      no_gaps = 1'b0;
      wait_drained();

      while (counted_items < RANDOM_ITEMS) begin
         random_session();
         if ($urandom_range(0, 9) == 0) wait_drained();
         if (phase_items >= 30) begin
            phase_items = 0;
            case ($urandom_range(0, 5))
               0:       size = 6'd1;
               1:       size = 6'd2;
               2:       size = 6'd32;
               3:       size = 6'd63;
               default: size = 6'($urandom);
            endcase
            case ($urandom_range(0, 4))
               0:       limit = 20'd0;
               1:       limit = 20'd1;
               2:       limit = TICK_MAX;
               default: limit = 20'($urandom_range(2, 40));
            endcase
            apply_settings(size, limit, 1'($urandom));
         end
      end

      wait_drained();
      repeat (32) @(posedge clock);
      if (sb.clean()) begin
         $display("console_line_editor_unit test passed");
      end else begin
         $display("console_line_editor_unit test failed");
      end
      $finish;
   end

endmodule
